@@ rtl/mvna_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex normal accumulator package
// Shared widths, command codes, request/result types and unit interfaces.
// ----------------------------------------------------------------------------
package mvna_pkg;

    localparam int VERTEX_DEPTH_DEF = 1024;
    localparam int IDX_W   = 10;
    localparam int COORD_W = 16;
    localparam int NORM_W  = 16;
    localparam int SUM_W   = 24;
    localparam int CNT_W   = 8;
    localparam int VTX_W   = 3 * COORD_W;
    localparam int ACC_W   = 3 * SUM_W + CNT_W;
    localparam int NUM_W   = 46;
    localparam int DEN_W   = 32;
    localparam int QUO_W   = 15;
    localparam int RAD_W   = 64;
    localparam int ROOT_W  = 32;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TRI   = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]                 command;
        logic [IDX_W-1:0]           vertex_index;
        logic [IDX_W-1:0]           second_corner;
        logic [IDX_W-1:0]           third_corner;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
    } req_t;

    typedef struct packed {
        logic signed [NORM_W-1:0]   normal_x;
        logic signed [NORM_W-1:0]   normal_y;
        logic signed [NORM_W-1:0]   normal_z;
        logic                       unused_vertex;
    } resp_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]    sum_x;
        logic signed [SUM_W-1:0]    sum_y;
        logic signed [SUM_W-1:0]    sum_z;
        logic [CNT_W-1:0]           count;
    } acc_t;

    typedef struct packed {
        logic               go;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   quot;
    } div_rsp_t;

    typedef struct packed {
        logic               go;
        logic [RAD_W-1:0]   rad;
    } sqrt_req_t;

    typedef struct packed {
        logic               done;
        logic [ROOT_W-1:0]  root;
    } sqrt_rsp_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_VRD_A,
        S_VRD_B,
        S_VRD_C,
        S_VRD_W,
        S_CROSS,
        S_MAG,
        S_NORM,
        S_SQ,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_NDIV_GO,
        S_NDIV_WAIT,
        S_UPD_RD,
        S_UPD_WR,
        S_ARD,
        S_AWAIT,
        S_ADIV_GO,
        S_ADIV_WAIT
    } state_t;

endpackage

@@ rtl/mvna_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module mvna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/mvna_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// One quotient bit per cycle; quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module mvna_div
    import mvna_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [NUM_W-1:0] rem_reg;
    logic [NUM_W-1:0] d_reg;
    logic [QUO_W-1:0] q_reg;
    logic [3:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;

    assign ge = rem_reg >= d_reg;

    // Control: start, count down, flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 4'd1;
                end
            end
        end
    end

    // Datapath: trial subtract against a shrinking divisor
    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            rem_reg <= req.num;
            d_reg   <= {req.den, {(NUM_W - DEN_W){1'b0}}};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - d_reg;
            end
            q_reg <= {q_reg[QUO_W-2:0], ge};
            d_reg <= d_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

@@ rtl/mvna_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root
// Digit-by-digit floor square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module mvna_sqrt
    import mvna_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic [RAD_W-1:0] x_reg;
    logic [RAD_W-1:0] r_reg;
    logic [RAD_W-1:0] bit_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RAD_W-1:0] trial;

    assign trial = r_reg + bit_reg;

    // Control: run until the lowest bit has been tried
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: subtract trial value, shift root
    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            x_reg   <= req.rad;
            r_reg   <= '0;
            bit_reg <= {2'b01, {(RAD_W - 2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (x_reg >= trial)
            begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = r_reg[ROOT_W-1:0];

endmodule

@@ rtl/mesh_vertex_normal_accumulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex normal accumulator
// Read: done is strobed in the same cycle that busy drops. Triangle: a cross
// product, a normalising shift, a square root and three divides, all but the
// cross product skipped when degenerate. One request at a time.
// Reset: a clearing pass zeroes the accumulators, busy high.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_accumulator
    import mvna_pkg::*;
#(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  req_t  request,
    output logic  done,
    output resp_t result,
    input  logic  cfg_we,
    input  logic  cfg_wdata
);

    localparam int AW = $clog2(VERTEX_DEPTH);
    localparam int RW = 17;

    state_t state_reg, state_next;

    logic [AW-1:0]       clr_reg;
    logic [IDX_W-1:0]    ia_reg, ib_reg, ic_reg;
    logic [VTX_W-1:0]    va_reg, vb_reg;
    logic signed [16:0]  e1_reg [3];
    logic signed [16:0]  e2_reg [3];
    logic [2:0]          step_reg;
    logic [1:0]          comp_reg;
    logic signed [63:0]  prod_reg;
    logic signed [34:0]  hold_reg;
    logic signed [34:0]  cr_reg [3];
    logic [33:0]         m_reg [3];
    logic [33:0]         big_reg;
    logic [RAD_W-1:0]    sq_reg;
    logic [ROOT_W-1:0]   len_reg;
    logic signed [NORM_W-1:0] n_reg [3];
    acc_t                acc_reg;
    resp_t               result_reg;
    logic                done_reg;
    logic                sign_reg;

    logic                accept;
    logic                a_ok, b_ok, c_ok;
    logic signed [31:0]  mul_a, mul_b;
    logic [33:0]         mag [3];
    logic [33:0]         mag_max;
    logic [IDX_W-1:0]    corner;
    logic signed [SUM_W-1:0] sum_sel;
    logic [SUM_W-1:0]    sum_mag;
    logic signed [NORM_W-1:0] q_signed;
    logic [30:0]         m_sel;

    logic                vram_we;
    logic [AW-1:0]       vram_waddr, vram_raddr;
    logic [VTX_W-1:0]    vram_wdata, vram_rdata;
    logic                aram_we;
    logic [AW-1:0]       aram_waddr, aram_raddr;
    acc_t                aram_wdata, aram_rd;
    logic [ACC_W-1:0]    aram_rdata;

    div_req_t            div_req;
    div_rsp_t            div_rsp;
    sqrt_req_t           sqrt_req;
    sqrt_rsp_t           sqrt_rsp;

    // Stores, shared divider and square root unit
    mvna_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_DEPTH)) u_vtx_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    mvna_ram #(.WIDTH(ACC_W), .DEPTH(VERTEX_DEPTH)) u_acc_ram (
        .clk   (clk),
        .we    (aram_we),
        .waddr (aram_waddr),
        .wdata (aram_wdata),
        .raddr (aram_raddr),
        .rdata (aram_rdata)
    );

    mvna_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mvna_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    assign aram_rd = acc_t'(aram_rdata);
    assign accept  = start && !busy;
    assign a_ok    = RW'(request.vertex_index)  < RW'(VERTEX_DEPTH);
    assign b_ok    = RW'(request.second_corner) < RW'(VERTEX_DEPTH);
    assign c_ok    = RW'(request.third_corner)  < RW'(VERTEX_DEPTH);

    // Cross product magnitudes and their maximum
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = cr_reg[i][34] ? 34'(-cr_reg[i]) : 34'(cr_reg[i]);
        end
        mag_max = mag[0];
        if (mag[1] > mag_max)
        begin
            mag_max = mag[1];
        end
        if (mag[2] > mag_max)
        begin
            mag_max = mag[2];
        end
    end

    // Per-component selections
    always_comb
    begin
        case (comp_reg)
            2'd0:
            begin
                corner  = ia_reg;
                sum_sel = acc_reg.sum_x;
                m_sel   = m_reg[0][30:0];
            end
            2'd1:
            begin
                corner  = ib_reg;
                sum_sel = acc_reg.sum_y;
                m_sel   = m_reg[1][30:0];
            end
            default:
            begin
                corner  = ic_reg;
                sum_sel = acc_reg.sum_z;
                m_sel   = m_reg[2][30:0];
            end
        endcase
        sum_mag  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
        q_signed = $signed({1'b0, div_rsp.quot});
    end

    // Multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_CROSS)
        begin
            case (step_reg)
                3'd0:
                begin
                    mul_a = 32'(e1_reg[1]);
                    mul_b = 32'(e2_reg[2]);
                end
                3'd1:
                begin
                    mul_a = 32'(e1_reg[2]);
                    mul_b = 32'(e2_reg[1]);
                end
                3'd2:
                begin
                    mul_a = 32'(e1_reg[2]);
                    mul_b = 32'(e2_reg[0]);
                end
                3'd3:
                begin
                    mul_a = 32'(e1_reg[0]);
                    mul_b = 32'(e2_reg[2]);
                end
                3'd4:
                begin
                    mul_a = 32'(e1_reg[0]);
                    mul_b = 32'(e2_reg[1]);
                end
                3'd5:
                begin
                    mul_a = 32'(e1_reg[1]);
                    mul_b = 32'(e2_reg[0]);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (state_reg == S_SQ)
        begin
            case (step_reg)
                3'd0:
                begin
                    mul_a = $signed({1'b0, m_reg[0][30:0]});
                end
                3'd1:
                begin
                    mul_a = $signed({1'b0, m_reg[1][30:0]});
                end
                3'd2:
                begin
                    mul_a = $signed({1'b0, m_reg[2][30:0]});
                end
                default:
                begin
                    mul_a = '0;
                end
            endcase
            mul_b = mul_a;
        end
    end

    // Next state and memory / unit controls
    always_comb
    begin
        state_next = state_reg;
        vram_we    = 1'b0;
        vram_waddr = AW'(request.vertex_index);
        vram_wdata = {request.coord_x, request.coord_y, request.coord_z};
        vram_raddr = AW'(ia_reg);
        aram_we    = 1'b0;
        aram_waddr = AW'(corner);
        aram_wdata = '0;
        aram_raddr = AW'(corner);
        div_req    = '0;
        sqrt_req   = '0;
        case (state_reg)
            S_CLEAR:
            begin
                aram_we    = 1'b1;
                aram_waddr = clr_reg;
                if (clr_reg == AW'(VERTEX_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (request.command)
                        CMD_WRITE:
                        begin
                            vram_we = a_ok;
                        end
                        CMD_TRI:
                        begin
                            if (a_ok && b_ok && c_ok)
                            begin
                                state_next = S_VRD_A;
                            end
                        end
                        CMD_READ:
                        begin
                            if (a_ok)
                            begin
                                state_next = S_ARD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_VRD_A:
            begin
                vram_raddr = AW'(ia_reg);
                state_next = S_VRD_B;
            end
            S_VRD_B:
            begin
                vram_raddr = AW'(ib_reg);
                state_next = S_VRD_C;
            end
            S_VRD_C:
            begin
                vram_raddr = AW'(ic_reg);
                state_next = S_VRD_W;
            end
            S_VRD_W:
            begin
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                if (step_reg == 3'd6)
                begin
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                state_next = (mag_max == '0) ? S_UPD_RD : S_NORM;
            end
            S_NORM:
            begin
                if (big_reg[33:31] == 3'd0 && big_reg[30])
                begin
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (step_reg == 3'd3)
                begin
                    state_next = S_SQRT_GO;
                end
            end
            S_SQRT_GO:
            begin
                sqrt_req.go  = 1'b1;
                sqrt_req.rad = sq_reg;
                state_next   = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (sqrt_rsp.done)
                begin
                    state_next = S_NDIV_GO;
                end
            end
            S_NDIV_GO:
            begin
                div_req.go  = 1'b1;
                div_req.num = NUM_W'({m_sel, 14'd0}) + NUM_W'(len_reg[ROOT_W-1:1]);
                div_req.den = len_reg;
                state_next  = S_NDIV_WAIT;
            end
            S_NDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (comp_reg == 2'd2) ? S_UPD_RD : S_NDIV_GO;
                end
            end
            S_UPD_RD:
            begin
                state_next = S_UPD_WR;
            end
            S_UPD_WR:
            begin
                aram_wdata.sum_x = aram_rd.sum_x + SUM_W'(n_reg[0]);
                aram_wdata.sum_y = aram_rd.sum_y + SUM_W'(n_reg[1]);
                aram_wdata.sum_z = aram_rd.sum_z + SUM_W'(n_reg[2]);
                aram_wdata.count = aram_rd.count + CNT_W'(1);
                aram_we          = aram_rd.count != COUNT_MAX;
                state_next       = (comp_reg == 2'd2) ? S_IDLE : S_UPD_RD;
            end
            S_ARD:
            begin
                aram_raddr = AW'(ia_reg);
                state_next = S_AWAIT;
            end
            S_AWAIT:
            begin
                state_next = (aram_rd.count == '0) ? S_IDLE : S_ADIV_GO;
            end
            S_ADIV_GO:
            begin
                div_req.go  = 1'b1;
                div_req.num = NUM_W'(sum_mag) + NUM_W'(acc_reg.count[CNT_W-1:1]);
                div_req.den = DEN_W'(acc_reg.count);
                state_next  = S_ADIV_WAIT;
            end
            S_ADIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (comp_reg == 2'd2) ? S_IDLE : S_ADIV_GO;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            sign_reg  <= 1'b0;
            step_reg  <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (cfg_we)
            begin
                sign_reg <= cfg_wdata;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                end
                S_IDLE:
                begin
                    if (accept && request.command == CMD_READ && !a_ok)
                    begin
                        done_reg <= 1'b1;
                    end
                end
                S_VRD_W, S_NORM:
                begin
                    step_reg <= '0;
                end
                S_CROSS, S_SQ:
                begin
                    step_reg <= step_reg + 3'd1;
                end
                S_MAG, S_SQRT_WAIT, S_AWAIT:
                begin
                    comp_reg <= '0;
                    if (state_reg == S_AWAIT && aram_rd.count == '0)
                    begin
                        done_reg <= 1'b1;
                    end
                end
                S_NDIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                    end
                end
                S_UPD_WR:
                begin
                    comp_reg <= comp_reg + 2'd1;
                end
                S_ADIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        comp_reg <= comp_reg + 2'd1;
                        done_reg <= comp_reg == 2'd2;
                    end
                end
                default:
                begin
                    comp_reg <= comp_reg;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ia_reg <= request.vertex_index;
                    ib_reg <= request.second_corner;
                    ic_reg <= request.third_corner;
                    if (request.command == CMD_READ && !a_ok)
                    begin
                        result_reg <= '{normal_x: '0, normal_y: '0, normal_z: '0,
                                        unused_vertex: 1'b1};
                    end
                end
            end
            S_VRD_B:
            begin
                va_reg <= vram_rdata;
            end
            S_VRD_C:
            begin
                vb_reg <= vram_rdata;
            end
            S_VRD_W:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_reg[i] <= 17'($signed(vb_reg[(2-i)*COORD_W +: COORD_W]))
                               - 17'($signed(va_reg[(2-i)*COORD_W +: COORD_W]));
                    e2_reg[i] <= 17'($signed(vram_rdata[(2-i)*COORD_W +: COORD_W]))
                               - 17'($signed(vb_reg[(2-i)*COORD_W +: COORD_W]));
                end
            end
            S_CROSS:
            begin
                // Pair up products: first of a pair is held, second subtracted
                if (step_reg != 3'd0)
                begin
                    if (step_reg[0])
                    begin
                        hold_reg <= 35'(prod_reg);
                    end
                    else
                    begin
                        cr_reg[2'(step_reg[2:1] - 2'd1)] <= hold_reg - 35'(prod_reg);
                    end
                end
            end
            S_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m_reg[i] <= mag[i];
                    n_reg[i] <= '0;
                end
                big_reg <= mag_max;
            end
            S_NORM:
            begin
                // Shift one place a cycle until the largest lies in [2^30, 2^31)
                if (big_reg[33:31] != 3'd0)
                begin
                    big_reg <= big_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                end
                else if (!big_reg[30])
                begin
                    big_reg <= big_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        m_reg[i] <= m_reg[i] << 1;
                    end
                end
            end
            S_SQ:
            begin
                if (step_reg == 3'd0)
                begin
                    sq_reg <= '0;
                end
                else
                begin
                    sq_reg <= sq_reg + RAD_W'(prod_reg);
                end
            end
            S_SQRT_WAIT:
            begin
                if (sqrt_rsp.done)
                begin
                    len_reg <= sqrt_rsp.root;
                end
            end
            S_NDIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    n_reg[comp_reg] <= (cr_reg[comp_reg] > 35'sd0) ? -q_signed : q_signed;
                end
            end
            S_AWAIT:
            begin
                acc_reg <= aram_rd;
                if (aram_rd.count == '0)
                begin
                    result_reg <= '{normal_x: '0, normal_y: '0, normal_z: '0,
                                    unused_vertex: 1'b1};
                end
                else
                begin
                    result_reg.unused_vertex <= 1'b0;
                end
            end
            S_ADIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    case (comp_reg)
                        2'd0:
                        begin
                            result_reg.normal_x <= (sum_sel[SUM_W-1] ^ sign_reg)
                                                   ? -q_signed : q_signed;
                        end
                        2'd1:
                        begin
                            result_reg.normal_y <= (sum_sel[SUM_W-1] ^ sign_reg)
                                                   ? -q_signed : q_signed;
                        end
                        default:
                        begin
                            result_reg.normal_z <= (sum_sel[SUM_W-1] ^ sign_reg)
                                                   ? -q_signed : q_signed;
                        end
                    endcase
                end
            end
            default:
            begin
                big_reg <= big_reg;
            end
        endcase
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.unused_vertex) |->
        (result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0))
        else $error("unused vertex with non-zero normal");

    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.command != CMD_READ) |=> !done)
        else $error("result for a request that gives none");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQ) |-> (big_reg[30] && big_reg[33:31] == 3'd0))
        else $error("normalised magnitude out of range");

endmodule
